/* design/ita_pkg.sv */
// Shared types, codes and helpers for the integer to ASCII converter.
// No dependencies; imported by ita_digits and integer_to_ascii_radix.
package ita_pkg;

    // Default and widest digit register depth
    localparam int MAX_DIGITS_DEF = 22;

    // Conversion selector codes
    localparam logic [2:0] CMD_SDEC   = 3'd0;
    localparam logic [2:0] CMD_UDEC   = 3'd1;
    localparam logic [2:0] CMD_OCT    = 3'd2;
    localparam logic [2:0] CMD_HEX_LO = 3'd3;
    localparam logic [2:0] CMD_HEX_UP = 3'd4;

    // Length codes
    localparam logic [1:0] LEN_32 = 2'd0;
    localparam logic [1:0] LEN_8  = 2'd1;
    localparam logic [1:0] LEN_16 = 2'd2;
    localparam logic [1:0] LEN_64 = 2'd3;

    // Character constants
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_LOWER = 8'h61;
    localparam logic [7:0] CHAR_NONE  = 8'h00;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    // Digit register operations
    typedef enum logic [2:0] {
        DIG_HOLD,
        DIG_CLEAR,
        DIG_LOAD_OCT,
        DIG_LOAD_HEX,
        DIG_DABBLE,
        DIG_SHIFT
    } dig_op_t;

    typedef struct packed {
        dig_op_t op;
        logic    shift_in;
    } dig_ctrl_t;

    // Digit value to ASCII
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CHAR_UPPER : CHAR_LOWER;
        if (d < 4'd10) begin
            return CHAR_ZERO + {4'b0, d};
        end
        return base + {4'b0, d} - 8'd10;
    endfunction

endpackage

/* design/integer_to_ascii_radix.sv */
// Top level of the integer to ASCII converter: sequencer, magnitude prep, handshakes.
// Depends on ita_pkg and ita_digits.
//
//  channel | direction | ports                                         | handshake
//  s_      | in        | s_value, s_cmd, s_length_code, s_suppress_zero | s_valid / s_ready
//  m_      | out       | m_character, m_is_last, m_is_empty             | m_valid / m_ready
//
// One request at a time. Capture and prep come first; decimal then runs one
// double-dabble step per bit of the cut width (8, 16, 32 or 64 bits), octal/hex none.
// Zero digits are dropped one per cycle, then one character per cycle while m_ready is
// high, a minus sign first for a negative value.
// Reset returns to idle; s_ready is low from acceptance until the last character is taken.
module integer_to_ascii_radix #(
    parameter int MAX_DIGITS = ita_pkg::MAX_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [63:0] s_value,
    input  logic [2:0]  s_cmd,
    input  logic [1:0]  s_length_code,
    input  logic        s_suppress_zero,
    input  logic        s_valid,
    output logic        s_ready,
    output logic [7:0]  m_character,
    output logic        m_is_last,
    output logic        m_is_empty,
    output logic        m_valid,
    input  logic        m_ready
);
    import ita_pkg::*;

    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(MAX_DIGITS - 1);

    state_t state_reg, state_next;

    logic [63:0]      value_reg;
    logic [2:0]       cmd_reg;
    logic [1:0]       len_reg;
    logic             sz_reg;
    logic [63:0]      bin_reg, bin_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             neg_reg, neg_next;
    logic             ovf_reg, ovf_next;

    logic [63:0] cut;
    logic [63:0] mag;
    logic [63:0] mag_aligned;
    logic [6:0]  width_bits;
    logic        is_signed;
    logic        neg;
    logic        is_empty_case;
    logic        is_oct;
    logic        is_hex;
    logic        oct_ovf;
    logic        skip_zero;
    logic        upper;
    logic [65:0] oct_ext;

    dig_ctrl_t   dig_ctrl;
    logic [3:0]  top_digit;
    logic        carry_out;

    ita_digits #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_digits (
        .aclk      (aclk),
        .ctrl      (dig_ctrl),
        .load_value(mag),
        .top_digit (top_digit),
        .carry_out (carry_out)
    );

    // Cut to width, sign-extend, take magnitude
    always_comb begin
        is_signed = (cmd_reg == CMD_SDEC);
        unique case (len_reg)
            LEN_8: begin
                cut         = {{56{is_signed & value_reg[7]}}, value_reg[7:0]};
                width_bits  = 7'd8;
            end
            LEN_16: begin
                cut         = {{48{is_signed & value_reg[15]}}, value_reg[15:0]};
                width_bits  = 7'd16;
            end
            LEN_64: begin
                cut         = value_reg;
                width_bits  = 7'd64;
            end
            default: begin
                cut         = {{32{is_signed & value_reg[31]}}, value_reg[31:0]};
                width_bits  = 7'd32;
            end
        endcase
        neg = is_signed & cut[63];
        mag = neg ? (~cut + 64'd1) : cut;
        unique case (len_reg)
            LEN_8:   mag_aligned = {mag[7:0], 56'd0};
            LEN_16:  mag_aligned = {mag[15:0], 48'd0};
            LEN_64:  mag_aligned = mag;
            default: mag_aligned = {mag[31:0], 32'd0};
        endcase
    end

    // Radix decode and misc flags
    always_comb begin
        is_oct = 1'b0;
        is_hex = 1'b0;
        case (cmd_reg) inside
            CMD_OCT:                is_oct = 1'b1;
            CMD_HEX_LO, CMD_HEX_UP: is_hex = 1'b1;
            default:                ;
        endcase
        oct_ext       = {2'b00, mag};
        oct_ovf       = (oct_ext >> (3 * MAX_DIGITS)) != 66'd0;
        is_empty_case = (mag == 64'd0) && sz_reg;
        skip_zero     = !ovf_reg && (top_digit == 4'd0) && (idx_reg != '0);
        upper         = (cmd_reg == CMD_HEX_UP);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_PREP;
            ST_PREP: begin
                if (is_empty_case)          state_next = ST_EMPTY;
                else if (is_oct || is_hex)  state_next = ST_SKIP;
                else                        state_next = ST_CONV;
            end
            ST_CONV: if (cnt_reg == 7'd1) state_next = ST_SKIP;
            ST_SKIP: begin
                if (!skip_zero) state_next = neg_reg ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN: if (m_ready) state_next = ST_EMIT;
            ST_EMIT: if (m_ready && idx_reg == '0) state_next = ST_IDLE;
            ST_EMPTY: if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and digit unit control
    always_comb begin
        s_ready          = 1'b0;
        m_valid          = 1'b0;
        m_character      = CHAR_NONE;
        m_is_last        = 1'b0;
        m_is_empty       = 1'b0;
        dig_ctrl.op       = DIG_HOLD;
        dig_ctrl.shift_in = bin_reg[63];
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_PREP: begin
                if (is_empty_case)  dig_ctrl.op = DIG_HOLD;
                else if (is_oct)    dig_ctrl.op = DIG_LOAD_OCT;
                else if (is_hex)    dig_ctrl.op = DIG_LOAD_HEX;
                else                dig_ctrl.op = DIG_CLEAR;
            end
            ST_CONV: dig_ctrl.op = DIG_DABBLE;
            ST_SKIP: if (skip_zero) dig_ctrl.op = DIG_SHIFT;
            ST_SIGN: begin
                m_valid     = 1'b1;
                m_character = CHAR_MINUS;
            end
            ST_EMIT: begin
                m_valid     = 1'b1;
                m_character = digit_char(top_digit, upper);
                m_is_last   = (idx_reg == '0);
                if (m_ready && idx_reg != '0) dig_ctrl.op = DIG_SHIFT;
            end
            ST_EMPTY: begin
                m_valid    = 1'b1;
                m_is_last  = 1'b1;
                m_is_empty = 1'b1;
            end
            default: ;
        endcase
    end

    // Datapath next values
    always_comb begin
        bin_next = bin_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        neg_next = neg_reg;
        ovf_next = ovf_reg;
        case (state_reg)
            ST_PREP: begin
                bin_next = mag_aligned;
                cnt_next = width_bits;
                idx_next = IDX_TOP;
                neg_next = neg & !is_empty_case;
                ovf_next = is_oct & oct_ovf;
            end
            ST_CONV: begin
                bin_next = {bin_reg[62:0], 1'b0};
                cnt_next = cnt_reg - 7'd1;
                ovf_next = ovf_reg | carry_out;
            end
            ST_SKIP: if (skip_zero) idx_next = idx_reg - 1'b1;
            ST_EMIT: if (m_ready && idx_reg != '0) idx_next = idx_reg - 1'b1;
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            value_reg <= s_value;
            cmd_reg   <= s_cmd;
            len_reg   <= s_length_code;
            sz_reg    <= s_suppress_zero;
        end
        bin_reg <= bin_next;
        cnt_reg <= cnt_next;
        idx_reg <= idx_next;
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
    end

`ifndef NO_ASSERTIONS
    // Never take a request while a character is offered
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request accepted while output pending");

    // An accepted request blocks further requests next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready high right after accept");

    // Empty result is always the last one
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_empty) |-> m_is_last)
        else $error("empty result not marked last");

    // Taking the last character frees the block
    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_is_last) |=> s_ready)
        else $error("not idle after last character");
`endif

endmodule

/* design/ita_digits.sv */
// Digit register of the converter: BCD double-dabble step, octal/hex load, shift out.
// Depends on ita_pkg.
module ita_digits #(
    parameter int MAX_DIGITS = ita_pkg::MAX_DIGITS_DEF
) (
    input  logic              aclk,
    input  ita_pkg::dig_ctrl_t ctrl,
    input  logic [63:0]       load_value,
    output logic [3:0]        top_digit,
    output logic              carry_out
);
    import ita_pkg::*;

    localparam int W = 4 * MAX_DIGITS;

    logic [W-1:0] digits_reg;
    logic [W-1:0] digits_next;
    logic [W-1:0] adj;
    logic [W-1:0] oct_load;
    logic [W-1:0] hex_load;
    logic [65:0]  ext;

    assign ext = {2'b00, load_value};

    // Per-lane add-3 correction and load images
    for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_lane
        assign adj[4*i +: 4] = (digits_reg[4*i +: 4] >= 4'd5) ?
                               digits_reg[4*i +: 4] + 4'd3 : digits_reg[4*i +: 4];
        assign oct_load[4*i +: 4] = {1'b0, ext[3*i +: 3]};
        if (i < 16) begin : g_hex
            assign hex_load[4*i +: 4] = load_value[4*i +: 4];
        end else begin : g_nohex
            assign hex_load[4*i +: 4] = 4'd0;
        end
    end

    // Next register value
    always_comb begin
        digits_next = digits_reg;
        unique case (ctrl.op)
            DIG_HOLD:     digits_next = digits_reg;
            DIG_CLEAR:    digits_next = '0;
            DIG_LOAD_OCT: digits_next = oct_load;
            DIG_LOAD_HEX: digits_next = hex_load;
            DIG_DABBLE:   digits_next = {adj[W-2:0], ctrl.shift_in};
            DIG_SHIFT:    digits_next = {digits_reg[W-5:0], 4'd0};
            default:      digits_next = digits_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        digits_reg <= digits_next;
    end

    assign top_digit = digits_reg[W-1 -: 4];
    assign carry_out = adj[W-1];

endmodule
